/* hdl/marker_segment_generator_assert.svh */
// Assertion macros for the marker segment generator checker.
`ifndef MARKER_SEGMENT_GENERATOR_ASSERT_SVH
`define MARKER_SEGMENT_GENERATOR_ASSERT_SVH

// Clocked check, masked while reset is asserted
`define MSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds through reset
`define MSG_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/msg_pkg.sv */
`default_nettype none

package msg_pkg;

  // Field widths
  localparam int CoordW   = 16;
  localparam int SizeW    = 15;
  localparam int ShapeW   = 3;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 15;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_SHAPE = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_SIZE  = CfgIdxW'(1);

  // Register reset values
  localparam logic [ShapeW-1:0] ShapeRst = ShapeW'(1);
  localparam logic [SizeW-1:0]  SizeRst  = SizeW'(7);

  // Shape codes
  localparam logic [ShapeW-1:0] SHAPE_DOT     = 3'd1;
  localparam logic [ShapeW-1:0] SHAPE_PLUS    = 3'd2;
  localparam logic [ShapeW-1:0] SHAPE_STAR    = 3'd3;
  localparam logic [ShapeW-1:0] SHAPE_SQUARE  = 3'd4;
  localparam logic [ShapeW-1:0] SHAPE_CROSS   = 3'd5;
  localparam logic [ShapeW-1:0] SHAPE_DIAMOND = 3'd6;

  // Queue between front and back end
  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  // Hold-off count loaded on reset and on every size write
  localparam logic [1:0] ScaleLat = 2'd3;

  // Largest offset magnitude in the shape ROM
  localparam int MaxMag = 4;

  typedef logic signed [3:0] offs_t;

  typedef struct packed {
    offs_t sx;
    offs_t sy;
    offs_t ex;
    offs_t ey;
  } seg_offs_t;

  // scale * 0 .. scale * MaxMag
  typedef logic [MaxMag:0][CoordW-1:0] scale_tbl_t;

  // One queued marker
  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic                     fin;
    logic [ShapeW-1:0]        shape;
    logic [1:0]               last_seg;
  } msg_entry_t;

  function automatic seg_offs_t mk(input int a, input int b, input int c, input int d);
    seg_offs_t r;
    r.sx = offs_t'(a);
    r.sy = offs_t'(b);
    r.ex = offs_t'(c);
    r.ey = offs_t'(d);
    return r;
  endfunction

  // Offset ROM, shape code must already be one of the six shapes
  function automatic seg_offs_t seg_rom(input logic [ShapeW-1:0] shape,
                                        input logic [1:0] seg);
    seg_offs_t r;
    r = mk(0, 0, 0, 0);
    unique case (shape)
      SHAPE_PLUS: begin
        case (seg)
          2'd0:    r = mk(0, -3, 0, 3);
          2'd1:    r = mk(-4, 0, 4, 0);
          default: r = mk(0, 0, 0, 0);
        endcase
      end
      SHAPE_STAR: begin
        case (seg)
          2'd0:    r = mk(0, -3, 0, 3);
          2'd1:    r = mk(3, 2, -3, -2);
          2'd2:    r = mk(3, -2, -3, 2);
          default: r = mk(0, 0, 0, 0);
        endcase
      end
      SHAPE_SQUARE: begin
        case (seg)
          2'd0:    r = mk(-4, -3, 4, -3);
          2'd1:    r = mk(4, -3, 4, 3);
          2'd2:    r = mk(4, 3, -4, 3);
          default: r = mk(-4, 3, -4, -3);
        endcase
      end
      SHAPE_CROSS: begin
        case (seg)
          2'd0:    r = mk(-4, -3, 4, 3);
          2'd1:    r = mk(-4, 3, 4, -3);
          default: r = mk(0, 0, 0, 0);
        endcase
      end
      SHAPE_DIAMOND: begin
        case (seg)
          2'd0:    r = mk(-4, 0, 0, -3);
          2'd1:    r = mk(0, -3, 4, 0);
          2'd2:    r = mk(4, 0, 0, 3);
          default: r = mk(0, 3, -4, 0);
        endcase
      end
      default: r = mk(0, 0, 0, 0);
    endcase
    return r;
  endfunction

  // Index of the final segment for each shape
  function automatic logic [1:0] seg_last(input logic [ShapeW-1:0] shape);
    logic [1:0] n;
    unique case (shape)
      SHAPE_PLUS:    n = 2'd1;
      SHAPE_STAR:    n = 2'd2;
      SHAPE_SQUARE:  n = 2'd3;
      SHAPE_CROSS:   n = 2'd1;
      SHAPE_DIAMOND: n = 2'd3;
      default:       n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* hdl/msg_scale.sv */
`default_nettype none

// Turns marker_size into round(size / UnitHeight), at least 1, and its
// small multiples. Three register stages; reciprocal multiply, then one
// correction step.
module msg_scale #(
  parameter int UnitHeight = 7
) (
  input  wire                          clk_i,
  input  wire  [msg_pkg::SizeW-1:0]    size_i,
  output msg_pkg::scale_tbl_t          tbl_o
);
  import msg_pkg::*;

  localparam int NW = CoordW;
  localparam int DW = $clog2(UnitHeight + 1);
  localparam int SH = NW + DW;
  localparam logic [SH:0]   Recip = (SH + 1)'((64'd1 << SH) / UnitHeight);
  localparam logic [NW-1:0] Half  = NW'(UnitHeight / 2);
  localparam logic [NW-1:0] Div   = NW'(UnitHeight);

  logic [NW-1:0]    num;
  logic [NW+SH:0]   prod;
  logic [NW-1:0]    n_q, q0_q;
  logic [NW+DW-1:0] back_mul;
  logic [NW-1:0]    rem;
  logic [NW-1:0]    quot;
  logic [NW-1:0]    scale_d, scale_q;
  scale_tbl_t       tbl_d, tbl_q;

  // stage 1: estimate, low by at most one
  assign num  = NW'(size_i) + Half;
  assign prod = (NW + SH + 1)'(num) * (NW + SH + 1)'(Recip);

  // stage 2: fix the estimate, floor at 1
  assign back_mul = (NW + DW)'(q0_q) * (NW + DW)'(UnitHeight);
  assign rem      = n_q - back_mul[NW-1:0];
  assign quot     = (rem >= Div) ? q0_q + NW'(1) : q0_q;
  assign scale_d  = (quot == '0) ? NW'(1) : quot;

  // stage 3: multiples by shifts and adds
  always_comb begin
    tbl_d[0] = '0;
    tbl_d[1] = scale_q;
    tbl_d[2] = scale_q << 1;
    tbl_d[3] = (scale_q << 1) + scale_q;
    tbl_d[4] = scale_q << 2;
  end

  always_ff @(posedge clk_i) begin
    n_q     <= num;
    q0_q    <= prod[SH +: NW];
    scale_q <= scale_d;
    tbl_q   <= tbl_d;
  end

  assign tbl_o = tbl_q;

endmodule

`default_nettype wire

/* hdl/msg_fifo.sv */
`default_nettype none

// Two-entry queue between front and back end.
module msg_fifo (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       push_i,
  input  wire msg_pkg::msg_entry_t  entry_i,
  output logic                      full_o,
  input  wire                       pop_i,
  output logic                      valid_o,
  output msg_pkg::msg_entry_t       entry_o
);
  import msg_pkg::*;

  msg_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/msg_front.sv */
`default_nettype none

// Accepts center-point beats, resolves the shape and its segment count,
// and queues them. Holds off input while the scale settles.
module msg_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire signed [msg_pkg::CoordW-1:0] center_x_i,
  input  wire signed [msg_pkg::CoordW-1:0] center_y_i,
  input  wire                           final_point_i,
  input  wire  [msg_pkg::ShapeW-1:0]    shape_i,
  input  wire                           size_wr_i,
  input  wire                           q_full_i,
  output logic                          push_o,
  output msg_pkg::msg_entry_t           entry_o
);
  import msg_pkg::*;

  logic [1:0]        settle_q;
  logic [ShapeW-1:0] shape;

  // unknown codes fall back to the dot
  always_comb begin
    shape = shape_i;
    if (shape_i < SHAPE_DOT || shape_i > SHAPE_DIAMOND) begin
      shape = SHAPE_DOT;
    end
  end

  assign in_ready_o = !q_full_i && (settle_q == '0);
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    entry_o.cx       = center_x_i;
    entry_o.cy       = center_y_i;
    entry_o.fin      = final_point_i;
    entry_o.shape    = shape;
    entry_o.last_seg = seg_last(shape);
  end

  // settle counter, restarted by reset and by a size write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= ScaleLat;
    end else if (size_wr_i) begin
      settle_q <= ScaleLat;
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

/* hdl/msg_back.sv */
`default_nettype none

// Walks the queued marker's segments into the output register, one
// per cycle while the output is not stalled.
module msg_back (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           q_valid_i,
  input  wire msg_pkg::msg_entry_t      q_entry_i,
  input  wire msg_pkg::scale_tbl_t      tbl_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic signed [msg_pkg::CoordW-1:0] start_x_o,
  output logic signed [msg_pkg::CoordW-1:0] start_y_o,
  output logic signed [msg_pkg::CoordW-1:0] end_x_o,
  output logic signed [msg_pkg::CoordW-1:0] end_y_o,
  output logic                          last_segment_o,
  output logic                          last_of_request_o
);
  import msg_pkg::*;

  logic [1:0]        seg_q;
  logic              adv, fire, last;
  seg_offs_t         offs;
  logic              out_valid_q;
  logic [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic              lseg_q, lreq_q;

  // centre plus scale times a small signed offset, wrapping
  function automatic logic [CoordW-1:0] place(input logic [CoordW-1:0] c,
                                              input offs_t off,
                                              input scale_tbl_t tbl);
    logic [3:0]        neg;
    logic [2:0]        mag;
    logic [CoordW-1:0] v;
    neg = -off;
    mag = off[3] ? neg[2:0] : off[2:0];
    v   = tbl[mag];
    return off[3] ? c - v : c + v;
  endfunction

  assign adv   = !out_valid_q || out_ready_i;
  assign fire  = q_valid_i && adv;
  assign last  = (seg_q == q_entry_i.last_seg);
  assign pop_o = fire && last;
  assign offs  = seg_rom(q_entry_i.shape, seg_q);

  // segment counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= q_valid_i;
      end
      if (fire) begin
        seg_q <= last ? 2'd0 : seg_q + 2'd1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      sx_q   <= place(q_entry_i.cx, offs.sx, tbl_i);
      sy_q   <= place(q_entry_i.cy, offs.sy, tbl_i);
      ex_q   <= place(q_entry_i.cx, offs.ex, tbl_i);
      ey_q   <= place(q_entry_i.cy, offs.ey, tbl_i);
      lseg_q <= last;
      lreq_q <= last && q_entry_i.fin;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign start_x_o         = sx_q;
  assign start_y_o         = sy_q;
  assign end_x_o           = ex_q;
  assign end_y_o           = ey_q;
  assign last_segment_o    = lseg_q;
  assign last_of_request_o = lreq_q;

endmodule

`default_nettype wire

/* hdl/marker_segment_generator.sv */
`default_nettype none

// Marker segment generator: each input beat is a marker centre; the block
// returns the line segments of the configured shape (dot 1, plus 2, star 3,
// square 4, cross 2, diamond 4 segments; shape codes 0 and 7 draw the dot)
// with every offset scaled by round(marker_size / UNIT_HEIGHT), at least 1,
// and coordinates wrapping to 16 bits. The back end fills the output
// register with one segment per cycle unless the output is stalled; a
// marker gives 1 to 4 segments and the next one follows without a gap. A
// two-entry queue keeps taking input beats while output is stalled, until
// it is full. After reset and every marker_size write the input is held
// off while the three-stage scale pipeline recomputes. Config writes are
// always accepted; write only while no marker is in flight.
module marker_segment_generator #(
  parameter int UNIT_HEIGHT = 7
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire signed [msg_pkg::CoordW-1:0]   center_x_i,
  input  wire signed [msg_pkg::CoordW-1:0]   center_y_i,
  input  wire                                final_point_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic signed [msg_pkg::CoordW-1:0]  start_x_o,
  output logic signed [msg_pkg::CoordW-1:0]  start_y_o,
  output logic signed [msg_pkg::CoordW-1:0]  end_x_o,
  output logic signed [msg_pkg::CoordW-1:0]  end_y_o,
  output logic                               last_segment_o,
  output logic                               last_of_request_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [msg_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire  [msg_pkg::CfgDataW-1:0]       cfg_data_i
);
  import msg_pkg::*;

  logic [ShapeW-1:0] shape_q;
  logic [SizeW-1:0]  size_q;
  logic              size_wr;
  scale_tbl_t        tbl;
  logic              push, q_full, q_valid, pop;
  msg_entry_t        push_entry, head_entry;

  // config registers
  assign cfg_ready_o = 1'b1;
  assign size_wr     = cfg_valid_i && (cfg_index_i == REG_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= ShapeRst;
      size_q  <= SizeRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_SHAPE) begin
        shape_q <= cfg_data_i[ShapeW-1:0];
      end
      if (size_wr) begin
        size_q <= cfg_data_i[SizeW-1:0];
      end
    end
  end

  msg_scale #(
    .UnitHeight (UNIT_HEIGHT)
  ) u_scale (
    .clk_i  (clk_i),
    .size_i (size_q),
    .tbl_o  (tbl)
  );

  msg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .final_point_i (final_point_i),
    .shape_i       (shape_q),
    .size_wr_i     (size_wr),
    .q_full_i      (q_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  msg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  msg_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_entry_i         (head_entry),
    .tbl_i             (tbl),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .start_x_o         (start_x_o),
    .start_y_o         (start_y_o),
    .end_x_o           (end_x_o),
    .end_y_o           (end_y_o),
    .last_segment_o    (last_segment_o),
    .last_of_request_o (last_of_request_o)
  );

endmodule

`default_nettype wire

/* hdl/msg_checker.sv */
`default_nettype none

`include "marker_segment_generator_assert.svh"

// Port-level checks on the marker segment generator.
module msg_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_ready_o,
  input wire                              out_valid_o,
  input wire                              out_ready_i,
  input wire signed [msg_pkg::CoordW-1:0] start_x_o,
  input wire signed [msg_pkg::CoordW-1:0] start_y_o,
  input wire signed [msg_pkg::CoordW-1:0] end_x_o,
  input wire signed [msg_pkg::CoordW-1:0] end_y_o,
  input wire                              last_segment_o,
  input wire                              last_of_request_o,
  input wire                              cfg_valid_i,
  input wire                              cfg_ready_o,
  input wire  [msg_pkg::CfgIdxW-1:0]      cfg_index_i
);
  import msg_pkg::*;

  // a stalled output beat stays valid
  `MSG_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "output beat dropped")

  // a stalled output beat keeps its payload
  `MSG_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(start_x_o) && $stable(start_y_o) && $stable(end_x_o) && $stable(end_y_o) && $stable(last_segment_o), "stalled beat changed")

  // end of request only on a marker's final segment
  `MSG_ASSERT_ANY(a_req_last, out_valid_o && last_of_request_o |-> last_segment_o, "request end off marker end")

  // input held off while the new scale settles
  `MSG_ASSERT(a_size_settle, cfg_valid_i && cfg_ready_o && cfg_index_i == REG_SIZE |=> !in_ready_o, "input taken during scale update")

endmodule

bind marker_segment_generator msg_checker u_msg_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import msg_pkg::*;

  localparam int UNIT_H      = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;
  localparam int MAX_REPORTS = 10;

  // Register index outside the map, writes to it must be dropped
  localparam logic [CfgIdxW-1:0] REG_SPARE = CfgIdxW'(15);
  // Shape codes outside the six shapes, both draw the dot
  localparam logic [ShapeW-1:0] SHAPE_NONE_LO = 3'd0;
  localparam logic [ShapeW-1:0] SHAPE_NONE_HI = 3'd7;

  typedef struct {
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic [CoordW-1:0] ex;
    logic [CoordW-1:0] ey;
    logic              last_seg;
    logic              last_req;
  } seg_beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CoordW-1:0]   center_x_i;
  logic [CoordW-1:0]   center_y_i;
  logic                final_point_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [CoordW-1:0]   start_x_o;
  logic [CoordW-1:0]   start_y_o;
  logic [CoordW-1:0]   end_x_o;
  logic [CoordW-1:0]   end_y_o;
  logic                last_segment_o;
  logic                last_of_request_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Shadow registers and expected segments
  logic [ShapeW-1:0] cur_shape;
  logic [SizeW-1:0]  cur_size;
  seg_beat_t         pending_segs[$];

  int  err_cnt;
  int  cycle_cnt;
  int  hold_len;
  bit  sender_idle;
  bit  receiver_idle;

  marker_segment_generator #(.UNIT_HEIGHT(UNIT_H)) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .center_x_i        (center_x_i),
    .center_y_i        (center_y_i),
    .final_point_i     (final_point_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .start_x_o         (start_x_o),
    .start_y_o         (start_y_o),
    .end_x_o           (end_x_o),
    .end_y_o           (end_y_o),
    .last_segment_o    (last_segment_o),
    .last_of_request_o (last_of_request_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Four signed nibbles: start x, start y, end x, end y
  function automatic logic [15:0] offs(input int a, input int b, input int c, input int d);
    return {4'(a), 4'(b), 4'(c), 4'(d)};
  endfunction

  // Offsets of one segment; anything but the six shapes is the dot
  function automatic logic [15:0] seg_offsets(input logic [ShapeW-1:0] shape,
                                              input int seg);
    logic [15:0] r;
    r = '0;
    case (shape)
      SHAPE_PLUS: begin
        case (seg)
          0: r = offs(0, -3, 0, 3);
          1: r = offs(-4, 0, 4, 0);
          default: r = '0;
        endcase
      end
      SHAPE_STAR: begin
        case (seg)
          0: r = offs(0, -3, 0, 3);
          1: r = offs(3, 2, -3, -2);
          2: r = offs(3, -2, -3, 2);
          default: r = '0;
        endcase
      end
      SHAPE_SQUARE: begin
        case (seg)
          0: r = offs(-4, -3, 4, -3);
          1: r = offs(4, -3, 4, 3);
          2: r = offs(4, 3, -4, 3);
          default: r = offs(-4, 3, -4, -3);
        endcase
      end
      SHAPE_CROSS: begin
        case (seg)
          0: r = offs(-4, -3, 4, 3);
          1: r = offs(-4, 3, 4, -3);
          default: r = '0;
        endcase
      end
      SHAPE_DIAMOND: begin
        case (seg)
          0: r = offs(-4, 0, 0, -3);
          1: r = offs(0, -3, 4, 0);
          2: r = offs(4, 0, 0, 3);
          default: r = offs(0, 3, -4, 0);
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic int seg_total(input logic [ShapeW-1:0] shape);
    case (shape)
      SHAPE_PLUS, SHAPE_CROSS:     return 2;
      SHAPE_STAR:                  return 3;
      SHAPE_SQUARE, SHAPE_DIAMOND: return 4;
      default:                     return 1;
    endcase
  endfunction

  // Centre plus scaled offset, wrapped to 16 bits
  function automatic logic [CoordW-1:0] place(input logic [CoordW-1:0] c, input int scale,
                                              input logic signed [3:0] off);
    return c + CoordW'(scale * int'(off));
  endfunction

  // Queue the segments one marker centre produces
  function automatic void draw_marker(input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
                                      input logic fin);
    int          scale;
    int          n;
    logic [15:0] o;
    seg_beat_t   b;
    scale = (int'(cur_size) + UNIT_H / 2) / UNIT_H;
    if (scale < 1) scale = 1;
    n = seg_total(cur_shape);
    for (int k = 0; k < n; k++) begin
      o = seg_offsets(cur_shape, k);
      b.sx = place(cx, scale, o[15:12]);
      b.sy = place(cy, scale, o[11:8]);
      b.ex = place(cx, scale, o[7:4]);
      b.ey = place(cy, scale, o[3:0]);
      b.last_seg = (k == n - 1);
      b.last_req = b.last_seg & fin;
      pending_segs.push_back(b);
    end
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Segment checker
  always @(posedge clk_i) begin
    seg_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_segs.size() == 0) begin
        flag_error($sformatf("unexpected segment (%0d,%0d)-(%0d,%0d)",
                             $signed(start_x_o), $signed(start_y_o),
                             $signed(end_x_o), $signed(end_y_o)));
      end else begin
        want = pending_segs.pop_front();
        if (start_x_o !== want.sx || start_y_o !== want.sy ||
            end_x_o !== want.ex || end_y_o !== want.ey ||
            last_segment_o !== want.last_seg || last_of_request_o !== want.last_req)
          flag_error($sformatf("segment exp (%0d,%0d)-(%0d,%0d) l%b r%b got (%0d,%0d)-(%0d,%0d) l%b r%b",
                               $signed(want.sx), $signed(want.sy), $signed(want.ex),
                               $signed(want.ey), want.last_seg, want.last_req,
                               $signed(start_x_o), $signed(start_y_o), $signed(end_x_o),
                               $signed(end_y_o), last_segment_o, last_of_request_o));
      end
    end
  end

  // Receiver: random stall before every beat, plus an optional long hold
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        gap = hold_len;
        hold_len = 0;
      end else begin
        gap = receiver_idle ? $urandom_range(0, 7) : 0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one marker centre; valid is left high after the beat
  task automatic send_marker(input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
                             input logic fin);
    int gap;
    gap = sender_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    center_x_i    <= cx;
    center_y_i    <= cy;
    final_point_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    draw_marker(cx, cy, fin);
  endtask

  // Drop valid and wait for every outstanding segment
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_SHAPE) cur_shape = data[ShapeW-1:0];
    else if (idx == REG_SIZE) cur_size = data[SizeW-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return CoordW'(16'h7fff - $urandom_range(0, 40));
      1: return CoordW'(16'h8000 + $urandom_range(0, 40));
      2: return CoordW'($urandom_range(0, 200) - 100);
      default: return CoordW'($urandom());
    endcase
  endfunction

  // Reset values: dot at scale 1, coordinate extremes
  task automatic test_reset_defaults();
    send_marker(16'h7fff, 16'h8000, 1'b0);
    send_marker(16'h0000, 16'hffff, 1'b1);
    settle_idle();
  endtask

  // Every shape code, the two unknown ones included
  task automatic test_every_shape();
    logic [ShapeW-1:0] shapes[8];
    shapes = '{SHAPE_NONE_LO, SHAPE_DOT, SHAPE_PLUS, SHAPE_STAR,
               SHAPE_SQUARE, SHAPE_CROSS, SHAPE_DIAMOND, SHAPE_NONE_HI};
    write_reg(REG_SIZE, CfgDataW'(14));
    foreach (shapes[i]) begin
      write_reg(REG_SHAPE, CfgDataW'(shapes[i]));
      send_marker(CoordW'(100 * i), CoordW'(-50 * i), i[0]);
      settle_idle();
    end
  endtask

  // Scale rounding and floor, largest size with wrapping sums
  task automatic test_scale_extremes();
    int sizes[6];
    sizes = '{0, 3, 4, 10, 11, 32767};
    write_reg(REG_SHAPE, CfgDataW'(SHAPE_SQUARE));
    foreach (sizes[i]) begin
      write_reg(REG_SIZE, CfgDataW'(sizes[i]));
      send_marker(i[0] ? 16'h7ffe : 16'h8001, i[0] ? 16'h8000 : 16'h7fff, 1'b1);
      settle_idle();
    end
    write_reg(REG_SHAPE, CfgDataW'(SHAPE_DIAMOND));
    send_marker(16'h0001, 16'hfffe, 1'b0);
    settle_idle();
  endtask

  // Write to a spare index leaves both registers alone
  task automatic test_spare_index();
    write_reg(REG_SPARE, 15'h7fff);
    send_marker(16'h1234, 16'hedcb, 1'b1);
    settle_idle();
  endtask

  // Long receiver hold while the sender keeps offering markers
  task automatic test_back_pressure();
    sender_idle = 1'b0;
    write_reg(REG_SHAPE, CfgDataW'(SHAPE_SQUARE));
    write_reg(REG_SIZE, CfgDataW'(21));
    hold_len = 80;
    for (int i = 0; i < 8; i++) send_marker(rand_coord(), rand_coord(), i == 7);
    settle_idle();
    sender_idle = 1'b1;
  endtask

  // Random phases, each with its own register setting
  task automatic test_random();
    int n_phase;
    n_phase = 10;
    for (int p = 0; p < n_phase; p++) begin
      sender_idle   = (p % 4 != 2);
      receiver_idle = (p % 4 != 2);
      write_reg(REG_SHAPE, CfgDataW'($urandom_range(0, 7)));
      if (p == 3) write_reg(REG_SIZE, CfgDataW'(32767));
      else if (p == 4) write_reg(REG_SIZE, CfgDataW'(0));
      else if ($urandom_range(0, 3) == 0) write_reg(REG_SIZE, CfgDataW'($urandom()));
      else write_reg(REG_SIZE, CfgDataW'($urandom_range(0, 60)));
      if ($urandom_range(0, 4) == 0)
        write_reg(CfgIdxW'($urandom_range(2, 15)), CfgDataW'($urandom()));
      for (int i = 0; i < 10; i++)
        send_marker(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
      settle_idle();
    end
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // Test sequence
  initial begin
    err_cnt       = 0;
    cycle_cnt     = 0;
    hold_len      = 0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    cur_shape     = ShapeRst;
    cur_size      = SizeRst;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    center_x_i    = '0;
    center_y_i    = '0;
    final_point_i = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_every_shape();
    test_scale_extremes();
    test_spare_index();
    test_back_pressure();
    test_random();

    settle_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_segs.size() != 0)
      flag_error($sformatf("%0d segments never arrived", pending_segs.size()));
    if (err_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
